@@ rtl/core/lkvc_pkg.sv @@
package lkvc_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 5;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	typedef struct packed {
		logic                     cmd;
		logic signed [KEY_W-1:0]  lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ACT,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic act;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

@@ rtl/core/lru_key_value_cache_unit.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Requests: drive req (cmd, lookup_key, write_value) with start; the word is
// taken at a rising edge where start is high and busy is low. cmd get looks
// a key up, cmd put updates the key or inserts it, evicting the least recent
// entry once cache_size entries are in use.
// Results: done is high for exactly one cycle with rsp (hit, read_value);
// read_value is -1 on a get miss and for every put. The receiver cannot hold
// results off, so rsp must be captured in that cycle.
// Sequence: after acceptance the scan reads the key memory one entry a
// cycle, then a drain state finishes the last compare, an act state
// updates the stores and a response state presents the result. A new
// request may be accepted in the cycle that done is shown; the block works
// on one request at a time.
// Configuration: wr_en with wr_data writes cache_size; write it only while
// idle. Zero acts as one and values above ENTRIES act as ENTRIES.
// Reset: arst_n clears every entry to empty and sets cache_size to 16; no
// clearing pass is needed, the block accepts work straight after reset.
module lru_key_value_cache_unit
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              wr_en,
	input  logic [SIZE_W-1:0] wr_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lkvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lkvc_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

endmodule

@@ rtl/core/lkvc_ctrl.sv @@
module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_ACT;
			end
			ST_ACT: begin
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				// take the next word while the result is shown
				state_nxt = start ? ST_SCAN : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		cmd.scan = 1'b0;
		cmd.act  = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_SCAN:  cmd.scan = 1'b1;
			ST_DRAIN: busy = 1'b1;
			ST_ACT:   cmd.act = 1'b1;
			ST_RESP: begin
				busy = 1'b0;
				done = 1'b1;
			end
			default:  busy = 1'b1;
		endcase
		cmd.load = start && !busy;
	end

endmodule

@@ rtl/core/lkvc_dpath.sv @@
module lkvc_dpath
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_stat_t          stat,
	input  req_t              req,
	output rsp_t              rsp,
	input  logic              wr_en,
	input  logic [SIZE_W-1:0] wr_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > SIZE_W) ? UW : SIZE_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// key and value stores
	logic [KEY_W-1:0]  key_mem [ENTRIES];
	logic [DATA_W-1:0] val_mem [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      rank_q [ENTRIES];
	logic [UW-1:0]      used_q;
	logic [SIZE_W-1:0]  cache_size_q;

	req_t              req_q;
	logic [IW-1:0]     idx_q;
	logic              cmp_s1;
	logic [IW-1:0]     idx_s1;
	logic              valid_s1;
	logic [IW-1:0]     rank_s1;
	logic [KEY_W-1:0]  key_rd_s1;
	logic [DATA_W-1:0] val_rd_q;

	logic          hit_q;
	logic [IW-1:0] found_q;
	logic [IW-1:0] found_rank_q;
	logic          free_any_q;
	logic [IW-1:0] free_idx_q;
	logic          vic_any_q;
	logic [IW-1:0] vic_idx_q;
	logic [IW-1:0] vic_rank_q;

	logic [CW-1:0] size_ext;
	logic [CW-1:0] eff_size;
	logic          room;
	logic          is_put;
	logic          do_fill;
	logic          do_evict;
	logic          do_install;
	logic [IW-1:0] tgt;

	assign stat.scan_last = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= SIZE_RESET;
		end else if (wr_en) begin
			cache_size_q <= wr_data;
		end
	end

	// zero acts as one, anything past the store depth as the depth
	always_comb begin
		size_ext = CW'(cache_size_q);
		eff_size = size_ext;
		if (size_ext == '0) begin
			eff_size = CW'(1);
		end else if (size_ext > CW'(ENTRIES)) begin
			eff_size = CW'(ENTRIES);
		end
	end

	assign room       = CW'(used_q) < eff_size;
	assign is_put     = (req_q.cmd == CMD_PUT);
	assign do_fill    = is_put && !hit_q && room && free_any_q;
	assign do_evict   = is_put && !hit_q && !room && vic_any_q;
	assign do_install = do_fill || do_evict;

	always_comb begin
		if (hit_q) begin
			tgt = found_q;
		end else if (do_fill) begin
			tgt = free_idx_q;
		end else begin
			tgt = vic_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan && !stat.scan_last) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			key_rd_s1 <= key_mem[idx_q];
			idx_s1    <= idx_q;
			valid_s1  <= valid_q[idx_q];
			rank_s1   <= rank_q[idx_q];
		end
		if (cmd.act && do_install) key_mem[tgt] <= req_q.lookup_key;
	end

	always_ff @(posedge clk) begin
		if (cmd.act) begin
			val_rd_q <= val_mem[found_q];
			if (is_put && (hit_q || do_install)) val_mem[tgt] <= req_q.write_value;
		end
	end

	// match, first free slot and least recent slot, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_q      <= 1'b0;
			free_any_q <= 1'b0;
			vic_any_q  <= 1'b0;
		end else if (cmp_s1) begin
			if (valid_s1 && key_rd_s1 == req_q.lookup_key && !hit_q) begin
				hit_q        <= 1'b1;
				found_q      <= idx_s1;
				found_rank_q <= rank_s1;
			end
			if (!valid_s1 && !free_any_q) begin
				free_any_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (valid_s1 && (!vic_any_q || rank_s1 > vic_rank_q)) begin
				vic_any_q  <= 1'b1;
				vic_idx_q  <= idx_s1;
				vic_rank_q <= rank_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.act) begin
			if (do_fill) used_q <= used_q + UW'(1);
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_q) begin
					// promote the hit slot, age those that were younger
					if (IW'(i) == found_q) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < found_rank_q) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end else if (do_install) begin
					if (IW'(i) == tgt) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end
		end
	end

	assign rsp.hit        = hit_q;
	assign rsp.read_value = (hit_q && req_q.cmd == CMD_GET) ? val_rd_q : MISS_VALUE;

endmodule

@@ rtl/core/lkvc_checker.sv @@
module lkvc_checker
	import lkvc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// a result never appears while a request is still at work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// work ends only by presenting its result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.hit) |-> (rsp.read_value == MISS_VALUE))
		else $error("miss returned a value other than -1");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

@@ tb/tb_lru_key_value_cache_unit.sv @@
module tb_lru_key_value_cache_unit;
	import lkvc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES  = 16;
	localparam int POOL_N   = 20;
	localparam int PHASE_N  = 240;
	localparam int MAX_GAP  = 6;
	localparam int SETTLE   = ENTRIES + 8;

	class lru_mirror;
		logic [KEY_W-1:0]  keys   [ENTRIES];
		logic [DATA_W-1:0] vals   [ENTRIES];
		bit                valid  [ENTRIES];
		int unsigned       rank   [ENTRIES];
		int                used;
		logic [SIZE_W-1:0] size_reg;
		rsp_t              due_replies[$];
		int                errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				keys[i]  = '0;
				vals[i]  = '0;
				valid[i] = 1'b0;
				rank[i]  = 0;
			end
			used     = 0;
			size_reg = SIZE_RESET;
			errors   = 0;
		endfunction

		function void resize(logic [SIZE_W-1:0] v);
			size_reg = v;
		endfunction

		function int live_size();
			int s;
			s = size_reg;
			if (s == 0)
				s = 1;
			if (s > ENTRIES)
				s = ENTRIES;
			return s;
		endfunction

		function int pending();
			return due_replies.size();
		endfunction

		// move a slot to the front; younger valid slots age by one
		function void promote(int idx);
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && i != idx && rank[i] < rank[idx])
					rank[i]++;
			rank[idx] = 0;
		endfunction

		function void fill(int idx, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i])
					rank[i]++;
			valid[idx] = 1'b1;
			keys[idx]  = k;
			vals[idx]  = v;
			rank[idx]  = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t exp;
			int   found;
			int   slot;
			found = -1;
			slot  = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (found < 0 && valid[i] && keys[i] == r.lookup_key)
					found = i;
			exp.hit        = (found >= 0);
			exp.read_value = MISS_VALUE;
			if (r.cmd == CMD_GET) begin
				if (found >= 0) begin
					promote(found);
					exp.read_value = vals[found];
				end
			end else if (found >= 0) begin
				vals[found] = r.write_value;
				promote(found);
			end else if (used < live_size()) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !valid[i])
						slot = i;
				if (slot >= 0) begin
					fill(slot, r.lookup_key, r.write_value);
					used++;
				end
			end else begin
				// evict the oldest valid slot, lowest index on a tie
				for (int i = 0; i < ENTRIES; i++)
					if (valid[i] && (slot < 0 || rank[i] > rank[slot]))
						slot = i;
				if (slot >= 0) begin
					valid[slot] = 1'b0;
					fill(slot, r.lookup_key, r.write_value);
				end
			end
			due_replies.push_back(exp);
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp;
			if (due_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: hit=%0b read_value=%h",
						got.hit, got.read_value);
				return;
			end
			exp = due_replies.pop_front();
			if (got.hit !== exp.hit || got.read_value !== exp.read_value) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: hit exp %0b got %0b, read_value exp %h got %h",
						exp.hit, got.hit, exp.read_value, got.read_value);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              done;
	rsp_t              rsp;
	logic              wr_en;
	logic [SIZE_W-1:0] wr_data;

	lru_mirror         mirror;
	logic [KEY_W-1:0]  key_pool[POOL_N];
	logic [KEY_W-1:0]  last_key;

	lru_key_value_cache_unit #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp),
		.wr_en  (wr_en),
		.wr_data(wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// results cannot be held off: take every word on the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_response(rsp);
	end

	function automatic req_t make_req(logic c, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		req_t r;
		r.cmd         = c;
		r.lookup_key  = k;
		r.write_value = v;
		return r;
	endfunction

	task automatic issue_request(req_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		mirror.note_request(r);
		last_key = r.lookup_key;
	endtask

	task automatic set_cache_size(logic [SIZE_W-1:0] v);
		start <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		mirror.resize(v);
	endtask

	function automatic req_t random_req();
		int               pick;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			k = last_key;
		else if (pick < 80)
			k = key_pool[$urandom_range(0, POOL_N - 1)];
		else
			k = $urandom;
		return make_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, $urandom);
	endfunction

	initial begin
		logic [SIZE_W-1:0] phase_size[8];
		int                max_gap;

		mirror   = new();
		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		wr_en    = 1'b0;
		wr_data  = '0;
		last_key = '0;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: extremes of key and value, update, miss
		issue_request(make_req(CMD_GET, 32'h0000_0000, 32'h1111_1111), 0);
		issue_request(make_req(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff), 0);
		issue_request(make_req(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000), 2);
		issue_request(make_req(CMD_PUT, 32'h0000_0000, 32'h0000_0000), 0);
		issue_request(make_req(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff), 1);
		issue_request(make_req(CMD_GET, 32'h8000_0000, 32'h0000_0000), 0);
		issue_request(make_req(CMD_GET, 32'hffff_ffff, 32'h0000_0000), 3);
		issue_request(make_req(CMD_PUT, 32'h0000_0000, 32'h5a5a_5a5a), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0000, 32'hffff_ffff), 0);
		issue_request(make_req(CMD_GET, 32'h1234_5678, 32'h0000_0000), 0);

		// shrink below the fill level: entries stay, puts evict the oldest
		set_cache_size(5'd2);
		issue_request(make_req(CMD_PUT, 32'h0000_0001, 32'ha5a5_a5a5), 0);
		issue_request(make_req(CMD_PUT, 32'h0000_0002, 32'h0000_0002), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0001, 32'h0000_0000), 0);
		issue_request(make_req(CMD_PUT, 32'h0000_0003, 32'h0000_0003), 4);
		issue_request(make_req(CMD_GET, 32'h0000_0002, 32'h0000_0000), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0001, 32'h0000_0000), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0003, 32'h0000_0000), 0);

		// zero acts as one
		set_cache_size(5'd0);
		issue_request(make_req(CMD_PUT, 32'h0000_0004, 32'hdead_beef), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0004, 32'h0000_0000), 0);
		issue_request(make_req(CMD_GET, 32'h0000_0003, 32'h0000_0000), 0);

		phase_size[0] = 5'd31;
		phase_size[1] = 5'd1;
		phase_size[2] = 5'd17;
		phase_size[3] = 5'd5;
		phase_size[4] = 5'd16;
		phase_size[5] = 5'd0;
		phase_size[6] = 5'd9;
		phase_size[7] = 5'd16;

		for (int p = 0; p < 8; p++) begin
			set_cache_size(phase_size[p]);
			max_gap = (p % 3 == 2) ? 0 : MAX_GAP;
			for (int n = 0; n < PHASE_N; n++)
				issue_request(random_req(), $urandom_range(0, max_gap));
		end

		start <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mirror.errors == 0 && mirror.pending() == 0)
			$display("tb_lru_key_value_cache_unit: clean");
		else
			$display("tb_lru_key_value_cache_unit: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_lru_key_value_cache_unit: errors");
		$finish;
	end

endmodule
